FILE: hw/rtl/pcms_pkg.sv
// ----------------------------------------------------------------------------
// pcms_pkg - shared types and constants for the paper-cutter motor sequencer
// Phase codes, register indexes, channel payload layouts and limit clipping.
// ----------------------------------------------------------------------------
package pcms_pkg;

  // Tick counter width; every limit is clipped to the counter maximum
  localparam int COUNT_WIDTH = 12;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  localparam count_t CMAX = '1;

  // Input channel layout
  localparam int IN_TDATA_W = 16;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_ADDR_W-1:0] CFG_CUTTER_PRESENT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEAVE_TIMEOUT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RETURN_TIMEOUT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLANK          = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BRAKE          = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_CUT     = 2'd1,
    OP_HOME    = 2'd2,
    OP_RECOVER = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_BLANK,
    PH_LEAVE,
    PH_RETURN,
    PH_REVERSE,
    PH_HOME_REV,
    PH_HOME_FWD,
    PH_BRK_FINISH,
    PH_BRK_REVERSE,
    PH_BRK_HOME_FWD,
    PH_BRK_ERROR,
    PH_BRK_PRE_ERROR,
    PH_ERR_WAIT
  } phase_t;

  typedef enum logic [1:0] {
    W_CONT,
    W_FOUND,
    W_TIMEOUT
  } wait_res_t;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_SUCCESS    = 3'd1,
    ST_NEVER_LEFT = 3'd2,
    ST_NEVER_RET  = 3'd3,
    ST_HOME_FAIL  = 3'd4
  } status_t;

  localparam logic [1:0] RECOVER_FINISH = 2'd2;

  typedef struct packed {
    logic        cutter_present;
    logic [11:0] leave_timeout_ms;
    logic [11:0] return_timeout_ms;
    logic [7:0]  blank_ms;
    logic [9:0]  brake_ms;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] cut_mode;
    logic       home_switch;
    logic       door_open;
    logic [1:0] recover_kind;
  } item_t;

  typedef struct packed {
    status_t status;
    logic    done_res;
    logic    error_latched;
    logic    busy_res;
    logic    motor_reverse;
    logic    motor_enable;
  } result_t;

  // Clip a 12-bit limit to the counter range
  function automatic count_t clip_lim(input logic [11:0] v);
    logic [16:0] w;
    w = 17'(v);
    if (w > 17'(CMAX)) begin
      return CMAX;
    end
    return w[COUNT_WIDTH-1:0];
  endfunction

endpackage

FILE: hw/rtl/pcms_cfg_regs.sv
// ----------------------------------------------------------------------------
// pcms_cfg_regs - configuration register file
// Holds the five timing and presence registers, written through the cfg port.
// ----------------------------------------------------------------------------
module pcms_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [pcms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pcms_pkg::CFG_DATA_W-1:0] cfg_data,
  output pcms_pkg::cfg_t                  cfg
);
  import pcms_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutter_present    <= 1'b1;
      cfg_r.leave_timeout_ms  <= 12'd1000;
      cfg_r.return_timeout_ms <= 12'd300;
      cfg_r.blank_ms          <= 8'd70;
      cfg_r.brake_ms          <= 10'd151;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_CUTTER_PRESENT: cfg_r.cutter_present    <= cfg_data[0];
        CFG_LEAVE_TIMEOUT:  cfg_r.leave_timeout_ms  <= cfg_data[11:0];
        CFG_RETURN_TIMEOUT: cfg_r.return_timeout_ms <= cfg_data[11:0];
        CFG_BLANK:          cfg_r.blank_ms          <= cfg_data[7:0];
        CFG_BRAKE:          cfg_r.brake_ms          <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/pcms_in_stage.sv
// ----------------------------------------------------------------------------
// pcms_in_stage - input register
// Captures one input transaction; frees up as soon as the core takes it.
// ----------------------------------------------------------------------------
module pcms_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pcms_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [pcms_pkg::IN_TUSER_W-1:0] in_tuser,
  input  logic                            advance,
  output logic                            item_valid,
  output pcms_pkg::item_t                 item
);
  import pcms_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.op           <= op_t'(in_tuser);
      item_r.cut_mode     <= in_tdata[7:0];
      item_r.home_switch  <= in_tdata[8];
      item_r.door_open    <= in_tdata[9];
      item_r.recover_kind <= in_tdata[11:10];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: hw/rtl/pcms_core.sv
// ----------------------------------------------------------------------------
// pcms_core - sequencer state and single-pass update
// Applies one item to the phase, tick counter and error state.
// ----------------------------------------------------------------------------
module pcms_core (
  input  logic              clk,
  input  logic              rst_n,
  input  pcms_pkg::cfg_t    cfg,
  input  logic              fire,
  input  pcms_pkg::item_t   item,
  output pcms_pkg::result_t result
);
  import pcms_pkg::*;

  phase_t     phase_r, phase_nxt;
  count_t     cnt_r, cnt_nxt;
  logic       cp_r, cp_nxt;
  logic       hom_r, hom_nxt;
  logic       err_r, err_nxt;
  status_t    pst_r, pst_nxt;
  logic       dso_r, dso_nxt;
  logic [1:0] rch_r, rch_nxt;
  logic       done;
  status_t    done_st;

  count_t lim_leave, lim_ret, lim_brake, lim_wait;
  logic   want;

  assign lim_leave = clip_lim(cfg.leave_timeout_ms);
  assign lim_ret   = clip_lim(cfg.return_timeout_ms);
  assign lim_brake = clip_lim((cfg.brake_ms == 10'd0) ? 12'd1 : {2'b00, cfg.brake_ms});

  // Leave waits for the switch to open; every other wait looks for home
  assign want     = (phase_r == PH_LEAVE);
  assign lim_wait = (phase_r == PH_LEAVE || phase_r == PH_REVERSE) ? lim_leave : lim_ret;

  // Next-state logic
  always_comb begin
    wait_res_t r;
    logic      hit;
    logic      resolve;
    logic      start;

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cp_nxt    = cp_r;
    hom_nxt   = hom_r;
    err_nxt   = err_r;
    pst_nxt   = pst_r;
    dso_nxt   = dso_r;
    rch_nxt   = rch_r;
    done      = 1'b0;
    done_st   = ST_NONE;
    r         = W_CONT;
    hit       = (item.home_switch == want);
    resolve   = 1'b0;
    start     = 1'b0;

    // Debounced switch wait, shared by all wait phases
    if (cp_r) begin
      cp_nxt = 1'b0;
      if (hit) begin
        r = (cnt_r < lim_wait) ? W_FOUND : W_TIMEOUT;
      end else begin
        if (cnt_nxt != CMAX) cnt_nxt = cnt_nxt + 1'b1;
        r = (cnt_nxt >= lim_wait) ? W_TIMEOUT : W_CONT;
      end
    end else if (hit) begin
      cp_nxt = 1'b1;
      if (cnt_nxt != CMAX) cnt_nxt = cnt_nxt + 1'b1;
    end else begin
      if (cnt_nxt != CMAX) cnt_nxt = cnt_nxt + 1'b1;
      r = (cnt_nxt >= lim_wait) ? W_TIMEOUT : W_CONT;
    end

    case (item.op)
      OP_TICK: begin
        case (phase_r)
          PH_BLANK: begin
            cnt_nxt = cnt_r;
            cp_nxt  = cp_r;
            if (cnt_nxt != CMAX) cnt_nxt = cnt_nxt + 1'b1;
            if (cnt_nxt >= COUNT_WIDTH'(cfg.blank_ms)) begin
              phase_nxt = PH_LEAVE;
              cp_nxt    = 1'b0;
              if (cnt_nxt >= lim_leave) begin
                pst_nxt   = ST_NEVER_LEFT;
                phase_nxt = PH_BRK_ERROR;
                cnt_nxt   = '0;
              end
            end
          end
          PH_LEAVE: begin
            if (r == W_FOUND) begin
              phase_nxt = PH_RETURN;
              cnt_nxt   = '0;
              cp_nxt    = 1'b0;
              if (lim_ret == '0) begin
                pst_nxt   = ST_NEVER_RET;
                phase_nxt = PH_BRK_REVERSE;
              end
            end else if (r == W_TIMEOUT) begin
              pst_nxt   = ST_NEVER_LEFT;
              phase_nxt = PH_BRK_ERROR;
              cnt_nxt   = '0;
              cp_nxt    = 1'b0;
            end
          end
          PH_RETURN: begin
            if (r == W_FOUND) begin
              phase_nxt = PH_BRK_FINISH;
              cnt_nxt   = '0;
              cp_nxt    = 1'b0;
            end else if (r == W_TIMEOUT) begin
              pst_nxt   = ST_NEVER_RET;
              phase_nxt = PH_BRK_REVERSE;
              cnt_nxt   = '0;
              cp_nxt    = 1'b0;
            end
          end
          PH_REVERSE: begin
            if (r != W_CONT) begin
              phase_nxt = PH_BRK_ERROR;
              cnt_nxt   = '0;
              cp_nxt    = 1'b0;
            end
          end
          PH_HOME_REV, PH_HOME_FWD: begin
            if (r == W_FOUND) begin
              phase_nxt = PH_BRK_FINISH;
              cnt_nxt   = '0;
              cp_nxt    = 1'b0;
            end else if (r == W_TIMEOUT) begin
              cnt_nxt = '0;
              cp_nxt  = 1'b0;
              if (phase_r == PH_HOME_REV) begin
                phase_nxt = PH_BRK_HOME_FWD;
              end else begin
                pst_nxt   = ST_HOME_FAIL;
                phase_nxt = PH_BRK_PRE_ERROR;
              end
            end
          end
          PH_BRK_FINISH, PH_BRK_REVERSE, PH_BRK_HOME_FWD, PH_BRK_ERROR,
          PH_BRK_PRE_ERROR: begin
            cnt_nxt = cnt_r;
            cp_nxt  = cp_r;
            if (cnt_nxt != CMAX) cnt_nxt = cnt_nxt + 1'b1;
            if (cnt_nxt >= lim_brake) begin
              case (phase_r)
                PH_BRK_FINISH: begin
                  phase_nxt = PH_IDLE;
                  cp_nxt    = 1'b0;
                  done      = 1'b1;
                  done_st   = ST_SUCCESS;
                end
                PH_BRK_REVERSE: begin
                  phase_nxt = (lim_leave == '0) ? PH_BRK_ERROR : PH_REVERSE;
                  cnt_nxt   = '0;
                  cp_nxt    = 1'b0;
                end
                PH_BRK_HOME_FWD: begin
                  phase_nxt = PH_HOME_FWD;
                  cnt_nxt   = '0;
                  cp_nxt    = 1'b0;
                  if (lim_ret == '0) begin
                    pst_nxt   = ST_HOME_FAIL;
                    phase_nxt = PH_BRK_PRE_ERROR;
                  end
                end
                PH_BRK_PRE_ERROR: begin
                  phase_nxt = PH_BRK_ERROR;
                  cnt_nxt   = '0;
                  cp_nxt    = 1'b0;
                end
                default: begin
                  phase_nxt = PH_ERR_WAIT;
                  cnt_nxt   = '0;
                  err_nxt   = 1'b1;
                  dso_nxt   = 1'b0;
                end
              endcase
            end
          end
          PH_ERR_WAIT: begin
            cnt_nxt = cnt_r;
            cp_nxt  = cp_r;
            if (item.door_open) begin
              dso_nxt = 1'b1;
            end else if (dso_r) begin
              resolve = 1'b1;
            end
          end
          default: begin
            cnt_nxt = cnt_r;
            cp_nxt  = cp_r;
          end
        endcase
      end
      OP_CUT: begin
        cnt_nxt = cnt_r;
        cp_nxt  = cp_r;
        if (cfg.cutter_present && phase_r == PH_IDLE) begin
          if (item.cut_mode > 8'd1) begin
            phase_nxt = PH_IDLE;
            cp_nxt    = 1'b0;
            done      = 1'b1;
            done_st   = ST_SUCCESS;
          end else begin
            start = 1'b1;
          end
        end
      end
      OP_HOME: begin
        cnt_nxt = cnt_r;
        cp_nxt  = cp_r;
        if (cfg.cutter_present && phase_r == PH_IDLE) begin
          hom_nxt = 1'b1;
          pst_nxt = ST_NONE;
          if (!item.home_switch) begin
            cp_nxt  = 1'b0;
            done    = 1'b1;
            done_st = ST_SUCCESS;
          end else begin
            phase_nxt = (lim_ret == '0) ? PH_BRK_HOME_FWD : PH_HOME_REV;
            cnt_nxt   = '0;
            cp_nxt    = 1'b0;
          end
        end
      end
      default: begin
        cnt_nxt = cnt_r;
        cp_nxt  = cp_r;
        rch_nxt = item.recover_kind;
        if (err_r && phase_r == PH_ERR_WAIT) begin
          resolve = 1'b1;
        end
      end
    endcase

    // Error clears: homing fails out, a cut finishes or starts over
    if (resolve) begin
      err_nxt = 1'b0;
      dso_nxt = 1'b0;
      if (hom_r) begin
        phase_nxt = PH_IDLE;
        cp_nxt    = 1'b0;
        done      = 1'b1;
        done_st   = ST_HOME_FAIL;
      end else begin
        if (rch_nxt == RECOVER_FINISH) begin
          phase_nxt = PH_IDLE;
          cp_nxt    = 1'b0;
          done      = 1'b1;
          done_st   = ST_SUCCESS;
        end else begin
          start = 1'b1;
        end
        rch_nxt = 2'd0;
      end
    end

    if (start) begin
      hom_nxt = 1'b0;
      pst_nxt = ST_NONE;
      cnt_nxt = '0;
      cp_nxt  = 1'b0;
      if (cfg.blank_ms == 8'd0) begin
        phase_nxt = (lim_leave == '0) ? PH_BRK_ERROR : PH_LEAVE;
        if (lim_leave == '0) pst_nxt = ST_NEVER_LEFT;
      end else begin
        phase_nxt = PH_BLANK;
      end
    end
  end

  // Output logic, from the phase after this item
  always_comb begin
    result.motor_enable  = phase_nxt inside {PH_BLANK, PH_LEAVE, PH_RETURN, PH_REVERSE,
                                             PH_HOME_REV, PH_HOME_FWD};
    result.motor_reverse = phase_nxt inside {PH_REVERSE, PH_HOME_REV};
    result.busy_res      = (phase_nxt != PH_IDLE);
    result.error_latched = err_nxt;
    result.done_res      = done;
    if (done) begin
      result.status = done_st;
    end else if (err_nxt) begin
      result.status = pst_nxt;
    end else begin
      result.status = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      cp_r    <= 1'b0;
      hom_r   <= 1'b0;
      err_r   <= 1'b0;
      pst_r   <= ST_NONE;
      dso_r   <= 1'b0;
      rch_r   <= 2'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      cp_r    <= cp_nxt;
      hom_r   <= hom_nxt;
      err_r   <= err_nxt;
      pst_r   <= pst_nxt;
      dso_r   <= dso_nxt;
      rch_r   <= rch_nxt;
    end
  end

endmodule

FILE: hw/rtl/pcms_out_reg.sv
// ----------------------------------------------------------------------------
// pcms_out_reg - result register
// Holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module pcms_out_reg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  pcms_pkg::result_t                result,
  output logic                             advance,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pcms_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pcms_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign advance = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_TDATA_W'(data_r);

endmodule

FILE: hw/rtl/paper_cutter_motor_sequencer.sv
// ----------------------------------------------------------------------------
// paper_cutter_motor_sequencer - DC cutter motor sequencer on millisecond ticks
// Drives a cut or homing sequence from tick and command transactions.
// ----------------------------------------------------------------------------
// Each input transaction (a 1 ms tick, start cut, start homing or recover)
// yields exactly one result transaction carrying the motor enable and
// direction, busy, error, done and status after that item. One item is taken
// per clock: an input register feeds a single pass of next-state logic whose
// result lands in the output register. The state updates once per fired item,
// so the rate is one transaction per cycle while the result register can load.
// The result register stalls only when the sink holds off out_tready.
// Configuration writes are accepted at any time (cfg_ready is tied high) but
// must only be made while the sequencer is idle with no results outstanding.
// ----------------------------------------------------------------------------
module paper_cutter_motor_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transaction
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] cut_mode, [8] home_switch, [9] door_open, [11:10] recover_kind
  input  logic [pcms_pkg::IN_TDATA_W-1:0] in_tdata,
  // [1:0] op
  input  logic [pcms_pkg::IN_TUSER_W-1:0] in_tuser,
  // result transaction
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] motor_enable, [1] motor_reverse, [2] busy_res, [3] error_latched,
  // [4] done_res, [7:5] status
  output logic [pcms_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pcms_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcms_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t result;
  logic    item_valid;
  logic    advance;
  logic    fire;

  assign cfg_ready = 1'b1;

  // Core consumes the held item whenever the result register can take it
  assign fire = item_valid && advance;

  pcms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcms_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Phase, tick count, debounce and error latch update once per fired item
  pcms_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  pcms_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the paper-cutter motor sequencer
// Drives tick and command transactions through the input stream, keeps an
// independent cycle-free model of the sequencer and compares every result
// transaction field by field. Covers reset values, directed edge cases,
// extreme register settings and randomised cut and homing sequences, with
// bursty input, a patterned sink and two long sink hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
  import pcms_pkg::*;

  localparam int          WATCHDOG_CYCLES = 1000000;
  localparam int          RAND_PHASES     = 8;
  localparam int          PHASE_ITEMS     = 30;
  localparam logic [7:0]  MODE_FULL       = 8'd0;
  localparam logic [7:0]  MODE_PARTIAL    = 8'd1;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT pins (all known from time zero)
  // --------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  always #10 clk = ~clk;

  paper_cutter_motor_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench bookkeeping
  // --------------------------------------------------------------------------
  item_t   pending_cmds[$];       // transactions waiting to be driven
  result_t predicted_outputs[$];  // predicted results, oldest first
  item_t   drv_cur;               // transaction currently offered
  int      items_sent       = 0;
  int      results_checked  = 0;
  int      mismatches       = 0;
  int      planned          = 0;
  int      settings_applied = 0;
  int      cycle_count      = 0;

  int      burst_left = 1;
  int      gap_left   = 0;
  int      rx_left    = 0;
  int      rx_mode    = 0;
  int      hold_left  = 0;
  int      holds_done = 0;

  // --------------------------------------------------------------------------
  // Sequencer model: its own copy of registers and state
  // --------------------------------------------------------------------------
  logic        c_present;
  logic [11:0] c_leave;
  logic [11:0] c_return;
  logic [7:0]  c_blank;
  logic [9:0]  c_brake;

  phase_t      sq_phase;
  count_t      sq_count;
  logic        sq_confirm;      // first matching switch sample seen
  logic        sq_homing;
  logic        sq_err;
  status_t     sq_pend;         // status shown while the error is latched
  logic        sq_door_seen;
  logic [1:0]  sq_recover;

  logic        step_done;       // per-transaction finish pulse
  status_t     step_status;

  function automatic count_t to_limit(logic [11:0] v);
    if (32'(v) > 32'(CMAX)) return CMAX;
    return count_t'(v);
  endfunction

  function automatic void seq_count_up();
    if (sq_count != CMAX) sq_count++;
  endfunction

  function automatic void seq_finish(status_t st);
    sq_phase    = PH_IDLE;
    sq_confirm  = 1'b0;
    step_done   = 1'b1;
    step_status = st;
  endfunction

  function automatic void seq_brake(phase_t nxt);
    sq_phase   = nxt;
    sq_count   = '0;
    sq_confirm = 1'b0;
  endfunction

  function automatic void seq_fail(phase_t nxt, status_t st);
    sq_pend = st;
    seq_brake(nxt);
  endfunction

  // Leave wait keeps the count from blanking, so it may time out on entry
  function automatic void seq_leave();
    sq_phase   = PH_LEAVE;
    sq_confirm = 1'b0;
    if (sq_count >= to_limit(c_leave)) seq_fail(PH_BRK_ERROR, ST_NEVER_LEFT);
  endfunction

  function automatic void seq_start_cut();
    sq_homing  = 1'b0;
    sq_pend    = ST_NONE;
    sq_count   = '0;
    sq_confirm = 1'b0;
    if (c_blank == 8'd0) seq_leave();
    else sq_phase = PH_BLANK;
  endfunction

  // Debounced switch wait: a match must be seen on two ticks in a row, and a
  // match confirmed with the count already at the limit counts as a timeout
  function automatic wait_res_t seq_wait(logic want, logic [11:0] lim_raw, logic sw);
    count_t lim;
    logic   hit;
    lim = to_limit(lim_raw);
    hit = (sw == want);
    if (sq_confirm) begin
      sq_confirm = 1'b0;
      if (hit) return (sq_count < lim) ? W_FOUND : W_TIMEOUT;
      seq_count_up();
    end else if (hit) begin
      sq_confirm = 1'b1;
      seq_count_up();
      return W_CONT;
    end else begin
      seq_count_up();
    end
    return (sq_count >= lim) ? W_TIMEOUT : W_CONT;
  endfunction

  // Error cleared: homing reports failure, a cut finishes or retries
  function automatic void seq_clear_error();
    sq_err       = 1'b0;
    sq_door_seen = 1'b0;
    if (sq_homing) begin
      seq_finish(ST_HOME_FAIL);
    end else if (sq_recover == RECOVER_FINISH) begin
      sq_recover = 2'd0;
      seq_finish(ST_SUCCESS);
    end else begin
      sq_recover = 2'd0;
      seq_start_cut();
    end
  endfunction

  function automatic result_t sequencer_advance(item_t it);
    result_t   res;
    count_t    brk_lim;
    wait_res_t r;
    step_done   = 1'b0;
    step_status = ST_NONE;
    case (it.op)
      OP_TICK: begin
        case (sq_phase)
          PH_BLANK: begin
            seq_count_up();
            if (sq_count >= c_blank) seq_leave();
          end
          PH_LEAVE: begin
            r = seq_wait(1'b1, c_leave, it.home_switch);
            if (r == W_FOUND) begin
              sq_phase   = PH_RETURN;
              sq_count   = '0;
              sq_confirm = 1'b0;
              if (to_limit(c_return) == '0) seq_fail(PH_BRK_REVERSE, ST_NEVER_RET);
            end else if (r == W_TIMEOUT) begin
              seq_fail(PH_BRK_ERROR, ST_NEVER_LEFT);
            end
          end
          PH_RETURN: begin
            r = seq_wait(1'b0, c_return, it.home_switch);
            if (r == W_FOUND) seq_brake(PH_BRK_FINISH);
            else if (r == W_TIMEOUT) seq_fail(PH_BRK_REVERSE, ST_NEVER_RET);
          end
          PH_REVERSE: begin
            r = seq_wait(1'b0, c_leave, it.home_switch);
            if (r != W_CONT) seq_brake(PH_BRK_ERROR);
          end
          PH_HOME_REV: begin
            r = seq_wait(1'b0, c_return, it.home_switch);
            if (r == W_FOUND) seq_brake(PH_BRK_FINISH);
            else if (r == W_TIMEOUT) seq_brake(PH_BRK_HOME_FWD);
          end
          PH_HOME_FWD: begin
            r = seq_wait(1'b0, c_return, it.home_switch);
            if (r == W_FOUND) seq_brake(PH_BRK_FINISH);
            else if (r == W_TIMEOUT) seq_fail(PH_BRK_PRE_ERROR, ST_HOME_FAIL);
          end
          PH_BRK_FINISH, PH_BRK_REVERSE, PH_BRK_HOME_FWD,
          PH_BRK_ERROR, PH_BRK_PRE_ERROR: begin
            // zero brake length behaves as one tick
            brk_lim = to_limit((c_brake == 10'd0) ? 12'd1 : {2'b00, c_brake});
            seq_count_up();
            if (sq_count >= brk_lim) begin
              case (sq_phase)
                PH_BRK_FINISH: seq_finish(ST_SUCCESS);
                PH_BRK_REVERSE: begin
                  sq_phase   = PH_REVERSE;
                  sq_count   = '0;
                  sq_confirm = 1'b0;
                  if (to_limit(c_leave) == '0) seq_brake(PH_BRK_ERROR);
                end
                PH_BRK_HOME_FWD: begin
                  sq_phase   = PH_HOME_FWD;
                  sq_count   = '0;
                  sq_confirm = 1'b0;
                  if (to_limit(c_return) == '0) seq_fail(PH_BRK_PRE_ERROR, ST_HOME_FAIL);
                end
                PH_BRK_PRE_ERROR: seq_brake(PH_BRK_ERROR);
                default: begin
                  sq_phase     = PH_ERR_WAIT;
                  sq_count     = '0;
                  sq_err       = 1'b1;
                  sq_door_seen = 1'b0;
                end
              endcase
            end
          end
          PH_ERR_WAIT: begin
            if (it.door_open) sq_door_seen = 1'b1;
            else if (sq_door_seen) seq_clear_error();
          end
          default: ;
        endcase
      end
      OP_CUT: begin
        if (c_present && sq_phase == PH_IDLE) begin
          if (it.cut_mode > MODE_PARTIAL) seq_finish(ST_SUCCESS);
          else seq_start_cut();
        end
      end
      OP_HOME: begin
        if (c_present && sq_phase == PH_IDLE) begin
          sq_homing = 1'b1;
          sq_pend   = ST_NONE;
          if (!it.home_switch) begin
            seq_finish(ST_SUCCESS);
          end else begin
            sq_phase   = PH_HOME_REV;
            sq_count   = '0;
            sq_confirm = 1'b0;
            if (to_limit(c_return) == '0) seq_brake(PH_BRK_HOME_FWD);
          end
        end
      end
      default: begin
        // recover choice is stored even when nothing is latched
        sq_recover = it.recover_kind;
        if (sq_err && sq_phase == PH_ERR_WAIT) seq_clear_error();
      end
    endcase
    res.motor_enable  = sq_phase inside {PH_BLANK, PH_LEAVE, PH_RETURN, PH_REVERSE,
                                         PH_HOME_REV, PH_HOME_FWD};
    res.motor_reverse = sq_phase inside {PH_REVERSE, PH_HOME_REV};
    res.busy_res      = (sq_phase != PH_IDLE);
    res.error_latched = sq_err;
    res.done_res      = step_done;
    res.status        = step_done ? step_status : (sq_err ? sq_pend : ST_NONE);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of transactions with random gaps, fed from pending_cmds.
  // The model is advanced on each accepted input transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    item_t nxt;
    logic  nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        predicted_outputs.push_back(sequencer_advance(drv_cur));
        items_sent <= items_sent + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_cmds.size() != 0) begin
          nxt = pending_cmds.pop_front();
          drv_cur   <= nxt;
          in_tdata  <= {4'b0000, nxt.recover_kind, nxt.door_open, nxt.home_switch,
                        nxt.cut_mode};
          in_tuser  <= nxt.op;
          nxt_valid = 1'b1;
          if (burst_left <= 1) begin
            // mostly short bursts, now and then a long unbroken stretch
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Sink hold-off: twice the sink stops while the driver keeps offering, so the
  // DUT fills and deasserts in_tready
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : holdoff_proc
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && items_sent >= 150) ||
                 (holds_done == 1 && items_sent >= 900)) begin
      hold_left  <= 400;
      holds_done <= holds_done + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result transaction against the oldest
  // prediction, and drives out_tready on a changing stall pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_proc
    result_t got;
    result_t want;
    logic    rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (predicted_outputs.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected result transaction, tdata=%02h", $realtime, out_tdata);
          mismatches++;
        end else begin
          want = predicted_outputs.pop_front();
          results_checked <= results_checked + 1;
          if (got.motor_enable  !== want.motor_enable  ||
              got.motor_reverse !== want.motor_reverse ||
              got.busy_res      !== want.busy_res      ||
              got.error_latched !== want.error_latched ||
              got.done_res      !== want.done_res      ||
              got.status        !== want.status) begin
            if (mismatches < 10) begin
              $display("[%0t] result %0d mismatch", $realtime, results_checked);
              $display("  exp en=%0b rev=%0b busy=%0b err=%0b done=%0b st=%0d",
                       want.motor_enable, want.motor_reverse, want.busy_res,
                       want.error_latched, want.done_res, want.status);
              $display("  got en=%0b rev=%0b busy=%0b err=%0b done=%0b st=%0d",
                       got.motor_enable, got.motor_reverse, got.busy_res,
                       got.error_latched, got.done_res, got.status);
            end
            mismatches++;
          end
        end
      end
      // stall pattern: always ready, coin toss, mostly ready, mostly stalled
      if (rx_left == 0) begin
        rx_left <= $urandom_range(50, 300);
        rx_mode <= $urandom_range(0, 3);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 1) == 1);
        2:       rdy = ($urandom_range(0, 3) != 0);
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      out_tready <= rdy && (hold_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog_proc
    cycle_count <= cycle_count + 1;
    if (cycle_count > WATCHDOG_CYCLES) begin
      $display("[%0t] watchdog expired: %0d predictions outstanding",
               $realtime, predicted_outputs.size());
      $display("** paper_cutter_motor_sequencer: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_cmd(op_t op, logic [7:0] mode, logic sw, logic door,
                                  logic [1:0] kind);
    item_t it;
    it.op           = op;
    it.cut_mode     = mode;
    it.home_switch  = sw;
    it.door_open    = door;
    it.recover_kind = kind;
    pending_cmds.push_back(it);
    planned++;
  endfunction

  // n ticks at switch level sw; with flip_pct > 0 the switch glitches, the
  // door flickers and stray commands are mixed in
  function automatic void add_ticks(logic sw, int n, int flip_pct);
    int i;
    for (i = 0; i < n; i++) begin
      if (flip_pct != 0 && $urandom_range(0, 99) < 4)
        add_cmd(op_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom),
                1'($urandom), 2'($urandom));
      add_cmd(OP_TICK, 8'($urandom),
              ($urandom_range(0, 99) < flip_pct) ? ~sw : sw,
              (flip_pct != 0 && $urandom_range(0, 99) < 3),
              2'($urandom));
    end
  endfunction

  // After a likely failure: door cycle, recover command, or leave it latched
  function automatic void plan_recovery();
    case ($urandom_range(0, 2))
      0: begin
        add_ticks(1'b0, $urandom_range(0, 2), 0);
        repeat ($urandom_range(1, 3)) add_cmd(OP_TICK, 8'($urandom), 1'b0, 1'b1, 2'd0);
        add_cmd(OP_TICK, 8'($urandom), 1'b0, 1'b0, 2'd0);
      end
      1: add_cmd(OP_RECOVER, 8'($urandom), 1'($urandom), 1'($urandom), 2'($urandom));
      default: ;
    endcase
    add_ticks(1'b0, c_brake + 3, 5);
  endfunction

  // A cut shaped around the current limits: blank, leave, away, return home
  function automatic void plan_cut();
    logic [7:0] mode;
    int         k0;
    int         k1;
    case ($urandom_range(0, 9))
      0:          mode = 8'($urandom);
      1, 2, 3, 4: mode = MODE_PARTIAL;
      default:    mode = MODE_FULL;
    endcase
    add_cmd(OP_CUT, mode, 1'($urandom), 1'($urandom), 2'($urandom));
    add_ticks(1'b0, c_blank + $urandom_range(0, 2), 50);
    k0 = ($urandom_range(0, 6) == 0) ? c_leave + 4 : $urandom_range(0, 12);
    add_ticks(1'b0, k0, 8);
    k1 = ($urandom_range(0, 3) == 0) ? c_return + $urandom_range(1, 4)
                                      : $urandom_range(2, c_return + 1);
    add_ticks(1'b1, k1, 6);
    add_ticks(1'b0, 2 * c_brake + $urandom_range(4, 8), 5);
    plan_recovery();
  endfunction

  function automatic void plan_homing();
    add_cmd(OP_HOME, 8'($urandom), ($urandom_range(0, 4) != 0), 1'($urandom),
            2'($urandom));
    add_ticks(1'b1, $urandom_range(0, 2 * c_return + c_brake + 4), 6);
    add_ticks(1'b0, 2 * c_brake + 6, 5);
    plan_recovery();
  endfunction

  // Wait until the driver is empty and every prediction has been matched
  task automatic settle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || predicted_outputs.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // Step the sequencer back to idle one transaction at a time
  task automatic drain_to_idle();
    settle();
    while (sq_phase != PH_IDLE) begin
      if (sq_phase == PH_ERR_WAIT) add_cmd(OP_RECOVER, 8'd0, 1'b0, 1'b0, RECOVER_FINISH);
      else add_cmd(OP_TICK, 8'd0, 1'b0, 1'b0, 2'd0);
      settle();
    end
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CUTTER_PRESENT: c_present = val[0];
      CFG_LEAVE_TIMEOUT:  c_leave   = val;
      CFG_RETURN_TIMEOUT: c_return  = val;
      CFG_BLANK:          c_blank   = val[7:0];
      CFG_BRAKE:          c_brake   = val[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic present, int leave, int ret, int blank, int brake);
    write_reg(CFG_CUTTER_PRESENT, {11'd0, present});
    write_reg(CFG_LEAVE_TIMEOUT, 12'(leave));
    write_reg(CFG_RETURN_TIMEOUT, 12'(ret));
    write_reg(CFG_BLANK, 12'(blank));
    write_reg(CFG_BRAKE, 12'(brake));
    settings_applied++;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : main_proc
    int ph;
    int target;
    int pick;

    // model at reset
    c_present    = 1'b1;
    c_leave      = 12'd1000;
    c_return     = 12'd300;
    c_blank      = 8'd70;
    c_brake      = 10'd151;
    sq_phase     = PH_IDLE;
    sq_count     = '0;
    sq_confirm   = 1'b0;
    sq_homing    = 1'b0;
    sq_err       = 1'b0;
    sq_pend      = ST_NONE;
    sq_door_seen = 1'b0;
    sq_recover   = 2'd0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one cut at the reset register values: blank, leave, return, full brake
    add_cmd(OP_CUT, MODE_FULL, 1'b0, 1'b0, 2'd0);
    add_ticks(1'b0, 70, 0);
    add_ticks(1'b1, 3, 0);
    add_ticks(1'b0, 3 + 151, 0);
    drain_to_idle();

    // Directed: shortest limits, one-tick brake
    apply_setting(1'b1, 71, 2, 0, 1);
    add_cmd(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0);            // idle tick
    add_cmd(OP_TICK, 8'hFF, 1'b1, 1'b1, 2'd3);            // idle tick, all bits set
    add_cmd(OP_RECOVER, 8'h00, 1'b0, 1'b0, RECOVER_FINISH); // early recover, stored
    add_cmd(OP_CUT, 8'hFF, 1'b0, 1'b0, 2'd0);             // unknown mode, done at once
    add_cmd(OP_CUT, 8'h02, 1'b1, 1'b1, 2'd0);
    add_cmd(OP_HOME, 8'h00, 1'b0, 1'b0, 2'd0);            // homing from home
    add_cmd(OP_CUT, MODE_FULL, 1'b0, 1'b0, 2'd0);         // no blanking: leave wait
    add_cmd(OP_CUT, MODE_PARTIAL, 1'b0, 1'b0, 2'd0);      // busy start, ignored
    add_cmd(OP_HOME, 8'h00, 1'b1, 1'b0, 2'd0);            // busy start, ignored
    add_cmd(OP_TICK, 8'h00, 1'b1, 1'b0, 2'd0);            // leave, debounced
    add_cmd(OP_TICK, 8'h00, 1'b1, 1'b0, 2'd0);
    add_cmd(OP_TICK, 8'h00, 1'b1, 1'b0, 2'd0);            // return: away
    add_cmd(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0);            // match at limit - 1
    add_cmd(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0);            // confirmed at limit: timeout
    add_cmd(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0);            // brake, then reverse
    add_cmd(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0);
    add_cmd(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0);            // home in reverse
    add_cmd(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0);            // error latched
    add_cmd(OP_TICK, 8'h00, 1'b0, 1'b1, 2'd0);            // door open
    add_cmd(OP_TICK, 8'h00, 1'b0, 1'b0, 2'd0);            // door shut: stored finish
    add_cmd(OP_HOME, 8'h00, 1'b1, 1'b0, 2'd0);            // homing, reverse first
    add_ticks(1'b1, 6, 0);                                // both attempts time out
    add_cmd(OP_RECOVER, 8'h00, 1'b0, 1'b0, 2'd1);         // recover while braking: stored, no error latched yet
    drain_to_idle();

    // No cutter fitted: starts do nothing
    apply_setting(1'b0, 71, 2, 0, 1);
    add_cmd(OP_CUT, MODE_FULL, 1'b1, 1'b0, 2'd0);
    add_cmd(OP_HOME, 8'h00, 1'b1, 1'b0, 2'd0);
    add_cmd(OP_CUT, 8'h80, 1'b0, 1'b0, 2'd0);
    add_cmd(OP_TICK, 8'h00, 1'b1, 1'b1, 2'd0);
    drain_to_idle();

    // Blank longer than the leave limit: times out as the leave wait opens
    apply_setting(1'b1, 71, 2, 72, 1);
    add_cmd(OP_CUT, MODE_FULL, 1'b0, 1'b0, 2'd0);
    add_ticks(1'b1, 74, 0);
    drain_to_idle();

    // Largest timeouts: blade leaves and returns well inside them
    apply_setting(1'b1, 4095, 4095, 0, 2);
    add_cmd(OP_CUT, MODE_PARTIAL, 1'b0, 1'b0, 2'd0);
    add_ticks(1'b1, 2, 0);
    add_ticks(1'b0, 5, 0);
    drain_to_idle();

    // Random phases
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: apply_setting(1'b1, $urandom_range(71, 140), $urandom_range(2, 50), 0,
                         $urandom_range(1, 12));
        1: apply_setting(1'b1, $urandom_range(71, 140), $urandom_range(2, 50),
                         $urandom_range(0, 30), $urandom_range(1, 12));
        2: apply_setting(1'($urandom_range(0, 3) != 0), $urandom_range(71, 100),
                         $urandom_range(2, 8), $urandom_range(0, 10), $urandom_range(1, 4));
        default: apply_setting(1'b1, 71, $urandom_range(2, 30), $urandom_range(71, 120),
                               $urandom_range(1, 6));
      endcase
      target = planned + PHASE_ITEMS;
      while (planned < target) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
          plan_cut();
        end else if (pick <= 7) begin
          plan_homing();
        end else if (pick == 8) begin
          repeat ($urandom_range(3, 10))
            add_cmd(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                    1'($urandom), 2'($urandom));
        end else begin
          add_ticks(1'($urandom), $urandom_range(2, 12), 50);
        end
      end
      drain_to_idle();
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d input transactions and %0d checked results over %0d settings.",
             items_sent, results_checked, settings_applied);
    $display("Included: cut, homing, busy starts, debounce at limit, timeouts, error recovery.");
    if (mismatches == 0 && predicted_outputs.size() == 0) begin
      $display("** paper_cutter_motor_sequencer: PASSED **");
    end else begin
      $display("%0d mismatches, %0d predictions outstanding", mismatches,
               predicted_outputs.size());
      $display("** paper_cutter_motor_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
